// ===== rtl/hrlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlc_pkg: shared types and constants for the request line checker
// Byte codes, status codes and the expected method and version text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrlc_pkg;

    // Status codes returned after the final byte of a line
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_REQUEST  = 3'd1,
        ST_NOT_ALLOWED  = 3'd2,
        ST_NOT_IMPL     = 3'd3,
        ST_BAD_VERSION  = 3'd4
    } t_status;

    // Field indexes within the line
    localparam logic [1:0] FIELD_METHOD  = 2'd0;
    localparam logic [1:0] FIELD_TARGET  = 2'd1;
    localparam logic [1:0] FIELD_VERSION = 2'd2;

    // Byte codes of interest
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_QUOTE = 8'h22;
    localparam logic [7:0] BYTE_DOT   = 8'h2E;
    localparam logic [7:0] BYTE_SLASH = 8'h2F;
    localparam logic [15:0] LINE_TAIL = 16'h0D0A;

    // Field lengths and the position counter ceiling
    localparam logic [3:0] METHOD_LEN  = 4'd3;
    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] POS_CAP     = 4'd9;
    localparam logic [1:0] SPACE_CAP   = 2'd3;

    // Expected method byte at a position below METHOD_LEN
    function automatic logic [7:0] method_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h47; // G
            4'd1:    c = 8'h45; // E
            4'd2:    c = 8'h54; // T
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected version byte at a position below VERSION_LEN
    function automatic logic [7:0] version_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h48; // H
            4'd1:    c = 8'h54; // T
            4'd2:    c = 8'h54; // T
            4'd3:    c = 8'h50; // P
            4'd4:    c = 8'h2F; // /
            4'd5:    c = 8'h31; // 1
            4'd6:    c = 8'h2E; // .
            4'd7:    c = 8'h31; // 1
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/http_request_line_checker.sv =====
// ----------------------------------------------------------------------------
// http_request_line_checker: streaming HTTP request line validation
// The status is registered and appears on the output in the cycle after the final byte.
// Throughput: one byte per cycle when not stalled; the per-byte flag and counter update is
// one short combinational step. Input stalls only while a status waits and
// the status side is not ready; a byte is taken in the cycle the status goes.
// Reset: synchronous active-low reset clears the checker state and the
// output valid; the state also returns to reset after every final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_line_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input byte stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] line_byte
    input  logic       s_axis_tlast,   // line_end
    // Status stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] status, [7:3] zero
);

    import hrlc_pkg::*;

    // Checker state
    logic [1:0]  r_space_count,  n_space_count;
    logic [1:0]  r_field_index,  n_field_index;
    logic [3:0]  r_field_position, n_field_position;
    logic        r_method_match, n_method_match;
    logic        r_slash_start,  n_slash_start;
    logic        r_quote_seen,   n_quote_seen;
    logic        r_dot_seen,     n_dot_seen;
    logic        r_version_match, n_version_match;
    logic [2:0]  r_field_nonempty, n_field_nonempty;
    logic [15:0] r_recent_bytes, n_recent_bytes;

    // Output register
    logic        r_out_valid;
    t_status     r_status, n_status;

    logic        in_fire;
    logic [7:0]  in_byte;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_byte       = s_axis_tdata;

    // Update flags and counters for one byte
    always_comb begin
        n_space_count    = r_space_count;
        n_field_index    = r_field_index;
        n_field_position = r_field_position;
        n_method_match   = r_method_match;
        n_slash_start    = r_slash_start;
        n_quote_seen     = r_quote_seen;
        n_dot_seen       = r_dot_seen;
        n_version_match  = r_version_match;
        n_field_nonempty = r_field_nonempty;
        n_recent_bytes   = {r_recent_bytes[7:0], in_byte};

        if (in_byte == BYTE_SPACE) begin
            if (r_space_count != SPACE_CAP) begin
                n_space_count = r_space_count + 2'd1;
            end
            if (r_field_index == FIELD_METHOD && r_field_position != METHOD_LEN) begin
                n_method_match = 1'b0;
            end
            if (r_field_index != FIELD_VERSION) begin
                n_field_index = r_field_index + 2'd1;
            end
            n_field_position = 4'd0;
        end else begin
            n_field_nonempty = r_field_nonempty | (3'b001 << r_field_index);
            case (r_field_index)
                FIELD_METHOD: begin
                    if (r_field_position >= METHOD_LEN ||
                        method_char(r_field_position) != in_byte) begin
                        n_method_match = 1'b0;
                    end
                end
                FIELD_TARGET: begin
                    if (r_field_position == 4'd0 && in_byte == BYTE_SLASH) begin
                        n_slash_start = 1'b1;
                    end
                    if (in_byte == BYTE_QUOTE) begin
                        n_quote_seen = 1'b1;
                    end
                    if (in_byte == BYTE_DOT) begin
                        n_dot_seen = 1'b1;
                    end
                end
                default: begin
                    if (r_field_position < VERSION_LEN &&
                        version_char(r_field_position) != in_byte) begin
                        n_version_match = 1'b0;
                    end
                end
            endcase
            if (r_field_position < POS_CAP) begin
                n_field_position = r_field_position + 4'd1;
            end
        end
    end

    // Pick the status from the updated state, first failing check wins
    always_comb begin
        if (n_space_count == SPACE_CAP) begin
            n_status = ST_BAD_REQUEST;
        end else if (n_field_nonempty != 3'b111) begin
            n_status = ST_BAD_REQUEST;
        end else if (n_recent_bytes != LINE_TAIL) begin
            n_status = ST_BAD_REQUEST;
        end else if (!n_method_match) begin
            n_status = ST_NOT_ALLOWED;
        end else if (!n_slash_start) begin
            n_status = ST_NOT_IMPL;
        end else if (n_quote_seen) begin
            n_status = ST_BAD_REQUEST;
        end else if (!n_dot_seen) begin
            n_status = ST_NOT_IMPL;
        end else if (!n_version_match || n_field_position < VERSION_LEN) begin
            n_status = ST_BAD_VERSION;
        end else begin
            n_status = ST_OK;
        end
    end

    // Advance state on each accepted byte; return to reset after the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_fire && s_axis_tlast)) begin
            r_space_count    <= 2'd0;
            r_field_index    <= FIELD_METHOD;
            r_field_position <= 4'd0;
            r_method_match   <= 1'b1;
            r_slash_start    <= 1'b0;
            r_quote_seen     <= 1'b0;
            r_dot_seen       <= 1'b0;
            r_version_match  <= 1'b1;
            r_field_nonempty <= 3'd0;
            r_recent_bytes   <= 16'd0;
        end else if (in_fire) begin
            r_space_count    <= n_space_count;
            r_field_index    <= n_field_index;
            r_field_position <= n_field_position;
            r_method_match   <= n_method_match;
            r_slash_start    <= n_slash_start;
            r_quote_seen     <= n_quote_seen;
            r_dot_seen       <= n_dot_seen;
            r_version_match  <= n_version_match;
            r_field_nonempty <= n_field_nonempty;
            r_recent_bytes   <= n_recent_bytes;
        end
    end

    // Hold the status until the downstream transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && s_axis_tlast) begin
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_status};

    // A final byte always produces a status in the next cycle
    a_last_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tlast) |=> m_axis_tvalid)
        else $error("final byte did not produce a status");

    // The state is back at reset after a final byte
    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tlast) |=>
        (r_space_count == 2'd0 && r_field_nonempty == 3'd0 && r_recent_bytes == 16'd0))
        else $error("state not cleared after final byte");

    // The field index never runs ahead of the space count
    a_index_tracks_spaces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_index <= r_space_count)
        else $error("field index ahead of space count");

    // A nonzero position means the current field has seen a byte
    a_position_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_field_position != 4'd0) |-> r_field_nonempty[r_field_index])
        else $error("position advanced without marking the field");

    // A shown status is one of the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd4 && m_axis_tdata[7:3] == 5'd0))
        else $error("status code out of range");

endmodule
